// ===== rtl/pdf_pkg.sv =====
// Shared types, constants and reset values for the filtered-derivative position PID.
`default_nettype none

package pdf_pkg;

   // Fixed-point format of the three gains.
   localparam int GAIN_FRAC_BITS = 12;
   localparam logic signed [31:0] TRUNC_BIAS = (32'sd1 <<< GAIN_FRAC_BITS) - 32'sd1;

   // Serial multiplier geometry: radix-4 digits taken from an 18-bit multiplier.
   localparam int MAC_W      = 64;
   localparam int MPL_W      = 18;
   localparam int DIGIT_W    = 2;
   localparam int MAC_DIGITS = MPL_W / DIGIT_W;
   localparam int MAC_CNT_W  = $clog2(MAC_DIGITS + 1);

   // Register file geometry.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Register reset values.
   localparam logic signed [31:0] RST_TARGET = 32'sd250;
   localparam logic [15:0]        RST_KP     = 16'd1556;
   localparam logic [15:0]        RST_KI     = 16'd1638;
   localparam logic [15:0]        RST_KD     = 16'd717;
   localparam logic [15:0]        RST_ALPHA  = 16'd58982;
   localparam logic [9:0]         RST_TPS    = 10'd40;
   localparam logic [14:0]        RST_LIMIT  = 15'd300;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TARGET = 3'd0,
      REG_KP     = 3'd1,
      REG_KI     = 3'd2,
      REG_KD     = 3'd3,
      REG_ALPHA  = 3'd4,
      REG_TPS    = 3'd5,
      REG_LIMIT  = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic signed [31:0] target;
      logic [15:0]        kp;
      logic [15:0]        ki;
      logic [15:0]        kd;
      logic [15:0]        alpha;
      logic [9:0]         tps;
      logic [14:0]        limit;
   } cfg_type;

   typedef struct packed {
      logic                    start;
      logic                    clear;
      logic signed [MAC_W-1:0] mcand;
      logic [MPL_W-1:0]        mplier;
   } mac_cmd_type;

   typedef struct packed {
      logic                    busy;
      logic signed [MAC_W-1:0] acc;
   } mac_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POS,
      ST_ERR,
      ST_SUM,
      ST_DG_GO,
      ST_DG_RUN,
      ST_MA_GO,
      ST_MA_RUN,
      ST_MB_GO,
      ST_MB_RUN,
      ST_KP_GO,
      ST_KP_RUN,
      ST_KI_GO,
      ST_KI_RUN,
      ST_CLAMP,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/pdf_csr.sv =====
// Configuration register file: gains, filter weight, prescaler and output limit.
`default_nettype none

module pdf_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pdf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pdf_pkg::CSR_DATA_W-1:0]   csr_data,
   output pdf_pkg::cfg_type                 cfg
);
   import pdf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken; an index beyond the list is dropped.
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            REG_TARGET: cfg_in.target = signed'(csr_data[31:0]);
            REG_KP:     cfg_in.kp     = csr_data[15:0];
            REG_KI:     cfg_in.ki     = csr_data[15:0];
            REG_KD:     cfg_in.kd     = csr_data[15:0];
            REG_ALPHA:  cfg_in.alpha  = csr_data[15:0];
            REG_TPS:    cfg_in.tps    = csr_data[9:0];
            REG_LIMIT:  cfg_in.limit  = csr_data[14:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target <= RST_TARGET;
         cfg_ff.kp     <= RST_KP;
         cfg_ff.ki     <= RST_KI;
         cfg_ff.kd     <= RST_KD;
         cfg_ff.alpha  <= RST_ALPHA;
         cfg_ff.tps    <= RST_TPS;
         cfg_ff.limit  <= RST_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/pdf_mac.sv =====
// Digit-serial multiply-accumulate unit, one radix-4 multiplier digit per cycle.
`default_nettype none

module pdf_mac (
   input  logic                  clock,
   input  logic                  reset,
   input  pdf_pkg::mac_cmd_type  mac_cmd,
   output pdf_pkg::mac_stat_type mac_stat
);
   import pdf_pkg::*;

   logic signed [MAC_W-1:0] mcand_ff, mcand_in;
   logic signed [MAC_W-1:0] mcand3_ff, mcand3_in;
   logic [MPL_W-1:0]        mplier_ff, mplier_in;
   logic signed [MAC_W-1:0] acc_ff, acc_in;
   logic [MAC_CNT_W-1:0]    count_ff, count_in;
   logic                    busy_ff, busy_in;
   logic signed [MAC_W-1:0] addend;

   assign mac_stat.busy = busy_ff;
   assign mac_stat.acc  = acc_ff;

   // Pick the multiple of the multiplicand that the low digit asks for.
   always_comb begin
      case (mplier_ff[DIGIT_W-1:0])
         2'd0:    addend = '0;
         2'd1:    addend = mcand_ff;
         2'd2:    addend = mcand_ff <<< 1;
         2'd3:    addend = mcand3_ff;
         default: addend = '0;
      endcase
   end

   // A start loads the operands and the triple; each busy cycle adds one digit's
   // partial product and moves the operands on by one digit.
   always_comb begin
      mcand_in  = mcand_ff;
      mcand3_in = mcand3_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      if (mac_cmd.start) begin
         mcand_in  = mac_cmd.mcand;
         mcand3_in = mac_cmd.mcand + (mac_cmd.mcand <<< 1);
         mplier_in = mac_cmd.mplier;
         if (mac_cmd.clear) begin
            acc_in = '0;
         end
         count_in = MAC_CNT_W'(MAC_DIGITS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_in    = acc_ff + addend;
         mcand_in  = mcand_ff <<< DIGIT_W;
         mcand3_in = mcand3_ff <<< DIGIT_W;
         mplier_in = mplier_ff >> DIGIT_W;
         count_in  = count_ff - MAC_CNT_W'(1);
         busy_in   = (count_ff != MAC_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mcand3_ff <= mcand3_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

endmodule

`default_nettype wire

// ===== rtl/position_pid_filtered_derivative.sv =====
// Top level: tick prescaler, PID state, control sequencer and result register.
// A tick that does not update only advances the prescaler and gives no beat; an update tick
// gives its rsp beat at the end of its sequence, and no new tick is taken until then.
// The sequence is five products on the shared radix-4 serial multiplier, each a load,
// nine digits and a hand-over, plus five single-state steps; rsp stalls hold it in ST_OUT.
// Synchronous active-high reset clears the control and controller state registers, no beat pends.
`default_nettype none

module position_pid_filtered_derivative (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [15:0] encoder_delta
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   // rsp_tdata: [15:0] motor_drive, [47:16] position_now
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import pdf_pkg::*;

   cfg_type      cfg;
   mac_cmd_type  mac_cmd;
   mac_stat_type mac_stat;

   state_type state_ff, state_in;

   logic [9:0]         tick_ff, tick_in;
   logic signed [31:0] position_ff, position_in;
   logic signed [31:0] prev_ff, prev_in;
   logic signed [39:0] sum_ff, sum_in;
   logic signed [47:0] deriv_ff, deriv_in;
   logic signed [15:0] delta_ff, delta_in;
   logic signed [31:0] err_ff, err_in;
   logic signed [32:0] diff_ff, diff_in;
   logic signed [47:0] t_ff, t_in;
   logic signed [63:0] u_ff, u_in;
   logic signed [31:0] clamp_ff, clamp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_drive_ff, rsp_drive_in;
   logic signed [31:0] rsp_pos_ff, rsp_pos_in;

   logic [10:0]        tick_next;
   logic [16:0]        alpha_inv;
   logic signed [63:0] lim_pos, lim_neg;
   logic signed [63:0] rounded;
   logic signed [31:0] trunc_adj, trunc_res, drive_neg;

   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      if (v[32] != v[31]) begin
         return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
      if (v[40] != v[39]) begin
         return v[40] ? 40'sh80_0000_0000 : 40'sh7f_ffff_ffff;
      end
      return v[39:0];
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
      if (!(&v[63:47]) && (|v[63:47])) begin
         return v[63] ? 48'sh8000_0000_0000 : 48'sh7fff_ffff_ffff;
      end
      return v[47:0];
   endfunction

   pdf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pdf_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .mac_cmd  (mac_cmd),
      .mac_stat (mac_stat)
   );

   // Port side.
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_pos_ff, rsp_drive_ff};

   // Helpers for the sequencer.
   assign tick_next = 11'(tick_ff) + 11'd1;
   assign alpha_inv = 17'h1_0000 - 17'(cfg.alpha);
   assign lim_pos   = signed'(64'(cfg.limit) << GAIN_FRAC_BITS);
   assign lim_neg   = -lim_pos;
   assign rounded   = mac_stat.acc + 64'sd32768;
   assign trunc_adj = clamp_ff[31] ? (clamp_ff + TRUNC_BIAS) : clamp_ff;
   assign trunc_res = trunc_adj >>> GAIN_FRAC_BITS;
   assign drive_neg = 32'sd0 - trunc_res;

   // Sequencer: next state, state updates and multiplier commands.
   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      position_in  = position_ff;
      prev_in      = prev_ff;
      sum_in       = sum_ff;
      deriv_in     = deriv_ff;
      delta_in     = delta_ff;
      err_in       = err_ff;
      diff_in      = diff_ff;
      t_in         = t_ff;
      u_in         = u_ff;
      clamp_in     = clamp_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_pos_in   = rsp_pos_ff;

      mac_cmd.start  = 1'b0;
      mac_cmd.clear  = 1'b1;
      mac_cmd.mcand  = '0;
      mac_cmd.mplier = '0;

      // The result register empties as soon as its beat is taken.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (tick_next < 11'(cfg.tps)) begin
                  tick_in = tick_next[9:0];
               end else begin
                  tick_in  = '0;
                  delta_in = signed'(req_tdata);
                  state_in = ST_POS;
               end
            end
         end
         ST_POS: begin
            position_in = sat32(33'(position_ff) + 33'(delta_ff));
            state_in    = ST_ERR;
         end
         ST_ERR: begin
            err_in   = sat32(33'(cfg.target) - 33'(position_ff));
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (cfg.ki == 16'd0) begin
               sum_in = '0;
            end else begin
               sum_in = sat40(41'(sum_ff) + 41'(err_ff));
            end
            diff_in  = 33'(err_ff) - 33'(prev_ff);
            prev_in  = err_ff;
            state_in = ST_DG_GO;
         end
         // Raw derivative: Kd times the error step.
         ST_DG_GO: begin
            mac_cmd.start  = 1'b1;
            mac_cmd.mcand  = 64'(diff_ff);
            mac_cmd.mplier = MPL_W'(cfg.kd);
            state_in       = ST_DG_RUN;
         end
         ST_DG_RUN: begin
            if (!mac_stat.busy) begin
               t_in     = sat48(mac_stat.acc);
               state_in = ST_MA_GO;
            end
         end
         // Filter: new sample weighted by one minus alpha ...
         ST_MA_GO: begin
            mac_cmd.start  = 1'b1;
            mac_cmd.mcand  = 64'(t_ff);
            mac_cmd.mplier = MPL_W'(alpha_inv);
            state_in       = ST_MA_RUN;
         end
         ST_MA_RUN: begin
            if (!mac_stat.busy) begin
               state_in = ST_MB_GO;
            end
         end
         // ... plus the previous output weighted by alpha, then rounded.
         ST_MB_GO: begin
            mac_cmd.start  = 1'b1;
            mac_cmd.clear  = 1'b0;
            mac_cmd.mcand  = 64'(deriv_ff);
            mac_cmd.mplier = MPL_W'(cfg.alpha);
            state_in       = ST_MB_RUN;
         end
         ST_MB_RUN: begin
            if (!mac_stat.busy) begin
               deriv_in = rounded[63:16];
               state_in = ST_KP_GO;
            end
         end
         // Proportional and integral terms share one accumulation.
         ST_KP_GO: begin
            mac_cmd.start  = 1'b1;
            mac_cmd.mcand  = 64'(err_ff);
            mac_cmd.mplier = MPL_W'(cfg.kp);
            state_in       = ST_KP_RUN;
         end
         ST_KP_RUN: begin
            if (!mac_stat.busy) begin
               state_in = ST_KI_GO;
            end
         end
         ST_KI_GO: begin
            mac_cmd.start  = 1'b1;
            mac_cmd.clear  = 1'b0;
            mac_cmd.mcand  = 64'(sum_ff);
            mac_cmd.mplier = MPL_W'(cfg.ki);
            state_in       = ST_KI_RUN;
         end
         ST_KI_RUN: begin
            if (!mac_stat.busy) begin
               u_in     = mac_stat.acc + 64'(deriv_ff);
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (u_ff > lim_pos) begin
               clamp_in = lim_pos[31:0];
            end else if (u_ff < lim_neg) begin
               clamp_in = lim_neg[31:0];
            end else begin
               clamp_in = u_ff[31:0];
            end
            state_in = ST_OUT;
         end
         // Hold here until the result register has room.
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_drive_in = drive_neg[15:0];
               rsp_pos_in   = position_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and controller state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         position_ff  <= '0;
         prev_ff      <= '0;
         sum_ff       <= '0;
         deriv_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         position_ff  <= position_in;
         prev_ff      <= prev_in;
         sum_ff       <= sum_in;
         deriv_ff     <= deriv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      delta_ff     <= delta_in;
      err_ff       <= err_in;
      diff_ff      <= diff_in;
      t_ff         <= t_in;
      u_ff         <= u_in;
      clamp_ff     <= clamp_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

endmodule

`default_nettype wire

// ===== rtl/pdf_checker.sv =====
// Port-level checks on the position PID top level, bound to it.
`default_nettype none

module pdf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // A stalled result beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // A fresh result only appears at the end of a control update.
   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared without an update in progress");

   // The drive is a clamped magnitude of at most 32767 and never the most negative code.
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:0] != 16'h8000)
      else $error("motor drive outside its range");

endmodule

bind position_pid_filtered_derivative pdf_checker u_pdf_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the filtered-derivative position PID controller.
`timescale 1ns / 1ps

module testbench;
   import pdf_pkg::*;

   localparam int     CLOCK_HALF   = 10;
   localparam int     DRAIN_CYCLES = 70;
   localparam int     TAIL_CYCLES  = 80;
   localparam int     HOLD_CYCLES  = 600;
   localparam longint CYCLE_LIMIT  = 3_000_000;

   localparam longint I32_HI = (64'sd1 <<< 31) - 64'sd1;
   localparam longint I32_LO = -(64'sd1 <<< 31);
   localparam longint I40_HI = (64'sd1 <<< 39) - 64'sd1;
   localparam longint I40_LO = -(64'sd1 <<< 39);
   localparam longint I48_HI = (64'sd1 <<< 47) - 64'sd1;
   localparam longint I48_LO = -(64'sd1 <<< 47);

   // One expected beat on the result channel.
   typedef struct packed {
      logic signed [15:0] drive;
      logic signed [31:0] pos;
   } beat_type;

   // Directed stimulus: a register write, a checked tick, or a tick with a hand-typed result.
   typedef enum logic [1:0] {ROW_WRITE, ROW_TICK, ROW_HAND} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      csr_reg_type        sel;
      logic [31:0]        value;
      logic signed [15:0] delta;
      logic signed [15:0] drive;
      logic signed [31:0] pos;
   } plan_row_type;

   localparam int PLAN_LEN = 29;
   localparam plan_row_type PLAN [PLAN_LEN] = '{
      // Every tick updates, and a zero limit forces the drive to zero.
      '{ROW_WRITE, REG_TPS,    32'd0,          16'sd0,      16'sd0,      32'sd0},
      '{ROW_WRITE, REG_LIMIT,  32'd0,          16'sd0,      16'sd0,      32'sd0},
      '{ROW_HAND,  REG_TARGET, 32'd0,          16'sh7FFF,   16'sd0,      32'sd32767},
      '{ROW_HAND,  REG_TARGET, 32'd0,          16'sh8000,   16'sd0,      32'shFFFFFFFF},
      '{ROW_HAND,  REG_TARGET, 32'd0,          16'sd0,      16'sd0,      32'shFFFFFFFF},
      // Full gains against extreme targets drive the output into both clamps.
      '{ROW_WRITE, REG_LIMIT,  32'd32767,      16'sd0,      16'sd0,      32'sd0},
      '{ROW_WRITE, REG_KP,     32'd65535,      16'sd0,      16'sd0,      32'sd0},
      '{ROW_WRITE, REG_KI,     32'd65535,      16'sd0,      16'sd0,      32'sd0},
      '{ROW_WRITE, REG_KD,     32'd65535,      16'sd0,      16'sd0,      32'sd0},
      '{ROW_WRITE, REG_TARGET, 32'h7FFF_FFFF,  16'sd0,      16'sd0,      32'sd0},
      '{ROW_HAND,  REG_TARGET, 32'd0,          16'sd1,      16'sh8001,   32'sd0},
      '{ROW_WRITE, REG_TARGET, 32'h8000_0000,  16'sd0,      16'sd0,      32'sd0},
      '{ROW_HAND,  REG_TARGET, 32'd0,          16'sh8000,   16'sh7FFF,   32'shFFFF8000},
      // Zero integral gain holds the error sum at zero.
      '{ROW_WRITE, REG_KI,     32'd0,          16'sd0,      16'sd0,      32'sd0},
      '{ROW_TICK,  REG_TARGET, 32'd0,          16'sd5,      16'sd0,      32'sd0},
      // Filter weight at both ends.
      '{ROW_WRITE, REG_ALPHA,  32'd0,          16'sd0,      16'sd0,      32'sd0},
      '{ROW_TICK,  REG_TARGET, 32'd0,          -16'sd7,     16'sd0,      32'sd0},
      '{ROW_WRITE, REG_ALPHA,  32'd65535,      16'sd0,      16'sd0,      32'sd0},
      '{ROW_TICK,  REG_TARGET, 32'd0,          16'sd100,    16'sd0,      32'sd0},
      '{ROW_WRITE, REG_KP,     32'd0,          16'sd0,      16'sd0,      32'sd0},
      '{ROW_WRITE, REG_KD,     32'd0,          16'sd0,      16'sd0,      32'sd0},
      '{ROW_WRITE, REG_TARGET, 32'd250,        16'sd0,      16'sd0,      32'sd0},
      '{ROW_TICK,  REG_TARGET, 32'd0,          16'sd0,      16'sd0,      32'sd0},
      // Lowering the step count below the running tick count updates at once.
      '{ROW_WRITE, REG_TPS,    32'd5,          16'sd0,      16'sd0,      32'sd0},
      '{ROW_TICK,  REG_TARGET, 32'd0,          16'sd1,      16'sd0,      32'sd0},
      '{ROW_TICK,  REG_TARGET, 32'd0,          16'sd2,      16'sd0,      32'sd0},
      '{ROW_TICK,  REG_TARGET, 32'd0,          16'sd3,      16'sd0,      32'sd0},
      '{ROW_WRITE, REG_TPS,    32'd2,          16'sd0,      16'sd0,      32'sd0},
      '{ROW_TICK,  REG_TARGET, 32'd0,          16'sd9,      16'sd0,      32'sd0}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // [15:0] encoder_delta
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;    // [15:0] motor_drive, [47:16] position_now
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   // Controller image: register copy and loop state.
   cfg_type     ctl_cfg;
   logic [9:0]  prescale_count;
   longint      plant_position;
   longint      last_error;
   longint      error_total;
   longint      deriv_filtered;

   beat_type    due_outputs[$];
   beat_type    hand_result;
   bit          hand_check;
   int          updates_done;
   int          fault_count;
   longint      cycle_count;
   bit          ticks_sent;
   bit          send_eager;
   bit          rsp_eager;
   bit          hold_request;

   position_pid_filtered_derivative dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   function automatic longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // One timer tick through the controller; returns 1 when the tick is an update.
   function automatic bit control_step(input logic signed [15:0] delta,
                                       output beat_type beat);
      int     next_count;
      longint err, diff, scaled, weight, mix, u, lim, whole;
      beat = '0;
      next_count = int'(prescale_count) + 1;
      if (next_count < int'(ctl_cfg.tps)) begin
         prescale_count = next_count[9:0];
         return 1'b0;
      end
      prescale_count = '0;
      plant_position = clip(plant_position + longint'(delta), I32_LO, I32_HI);
      err = clip(longint'($signed(ctl_cfg.target)) - plant_position, I32_LO, I32_HI);
      if (ctl_cfg.ki == 16'd0)
         error_total = 0;
      else
         error_total = clip(error_total + err, I40_LO, I40_HI);
      diff = err - last_error;
      last_error = err;
      scaled = clip(longint'(ctl_cfg.kd) * diff, I48_LO, I48_HI);
      weight = longint'(ctl_cfg.alpha);
      mix = scaled * (65536 - weight) + deriv_filtered * weight;
      deriv_filtered = (mix + 64'sd32768) >>> 16;
      u = longint'(ctl_cfg.kp) * err + longint'(ctl_cfg.ki) * error_total + deriv_filtered;
      lim = longint'(ctl_cfg.limit) <<< GAIN_FRAC_BITS;
      u = clip(u, -lim, lim);
      whole = u / (64'sd1 <<< GAIN_FRAC_BITS);
      beat.drive = 16'(-whole);
      beat.pos = 32'(plant_position);
      return 1'b1;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (send_eager || roll < 60) return 0;
      if (roll < 95) return $urandom_range(1, 4);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [15:0] pick_gain();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 16'd0;
      if (roll == 1) return 16'hFFFF;
      if (roll < 6) return 16'($urandom_range(0, 4096));
      return 16'($urandom());
   endfunction

   function automatic logic signed [15:0] pick_delta(bit pull_down);
      if ($urandom_range(0, 4) == 0) return 16'($urandom());
      if (pull_down) return -16'($urandom_range(0, 64));
      return 16'($urandom_range(0, 128)) - 16'sd64;
   endfunction

   // Offer one tick beat; called and returning at a falling edge.
   task automatic send_tick(input logic signed [15:0] delta, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= delta;
      ticks_sent = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Register write once the controller is idle; called and returning at a falling edge.
   task automatic csr_write(input csr_reg_type sel, input logic [31:0] value);
      req_tvalid <= 1'b0;
      if (ticks_sent) begin
         while (due_outputs.size() != 0) @(negedge clock);
         repeat (DRAIN_CYCLES) @(negedge clock);
         ticks_sent = 1'b0;
      end
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Result receiver: random stalls, eager stretches, and one long hold-off on request.
   initial begin
      int hold_left;
      int stall_left;
      hold_left  = 0;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!rsp_eager && $urandom_range(0, 3) == 0) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90)
                                                    : $urandom_range(0, 3);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Monitor: track register writes, predict on each accepted tick, check each result beat.
   always @(posedge clock) begin
      beat_type pred;
      beat_type got;
      beat_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("DONE: errors detected");
         $finish;
      end else if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_TARGET: ctl_cfg.target = csr_data;
               REG_KP:     ctl_cfg.kp     = csr_data[15:0];
               REG_KI:     ctl_cfg.ki     = csr_data[15:0];
               REG_KD:     ctl_cfg.kd     = csr_data[15:0];
               REG_ALPHA:  ctl_cfg.alpha  = csr_data[15:0];
               REG_TPS:    ctl_cfg.tps    = csr_data[9:0];
               REG_LIMIT:  ctl_cfg.limit  = csr_data[14:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (control_step($signed(req_tdata), pred)) begin
               updates_done++;
               due_outputs.push_back(hand_check ? hand_result : pred);
            end else if (hand_check) begin
               fault_count++;
               $display("%0t: tick gave no update where a result was expected", $time);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.drive = rsp_tdata[15:0];
            got.pos   = rsp_tdata[47:16];
            if (due_outputs.size() == 0) begin
               fault_count++;
               $display("%0t: unexpected result beat, drive %0d position %0d",
                        $time, got.drive, got.pos);
            end else begin
               want = due_outputs.pop_front();
               if (got !== want) begin
                  fault_count++;
                  $display("%0t: drive expected %0d got %0d, position expected %0d got %0d",
                           $time, want.drive, got.drive, want.pos, got.pos);
               end
            end
         end
      end
   end

   // Stimulus: reset, directed table, then randomised phases.
   initial begin
      int          goal;
      logic [15:0] tps_pick;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      hand_check     = 1'b0;
      hand_result    = '0;
      updates_done   = 0;
      fault_count    = 0;
      cycle_count    = 0;
      ticks_sent     = 1'b0;
      send_eager     = 1'b0;
      rsp_eager      = 1'b0;
      hold_request   = 1'b0;
      ctl_cfg        = '{RST_TARGET, RST_KP, RST_KI, RST_KD, RST_ALPHA, RST_TPS, RST_LIMIT};
      prescale_count = '0;
      plant_position = 0;
      last_error     = 0;
      error_total    = 0;
      deriv_filtered = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table.
      for (int i = 0; i < PLAN_LEN; i++) begin
         if (PLAN[i].kind == ROW_WRITE) begin
            csr_write(PLAN[i].sel, PLAN[i].value);
         end else begin
            hand_check  = (PLAN[i].kind == ROW_HAND);
            hand_result = '{PLAN[i].drive, PLAN[i].pos};
            send_tick(PLAN[i].delta, pick_gap());
         end
      end
      hand_check = 1'b0;

      // Random phases, each under its own register setting.
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: begin
               // Reset values written back; forty ticks per update.
               csr_write(REG_TARGET, RST_TARGET);
               csr_write(REG_KP, 32'(RST_KP));
               csr_write(REG_KI, 32'(RST_KI));
               csr_write(REG_KD, 32'(RST_KD));
               csr_write(REG_ALPHA, 32'(RST_ALPHA));
               csr_write(REG_TPS, 32'(RST_TPS));
               csr_write(REG_LIMIT, 32'(RST_LIMIT));
               goal = 1;
            end
            1: begin
               // A long prescale period.
               csr_write(REG_TARGET, 32'($urandom_range(0, 4000)) - 32'd2000);
               csr_write(REG_TPS, 32'd64);
               csr_write(REG_LIMIT, 32'($urandom_range(0, 32767)));
               goal = 1;
            end
            2: begin
               // Integral wind-up into the error sum ceiling.
               csr_write(REG_TARGET, 32'h7FFF_FFFF);
               csr_write(REG_KP, 32'(pick_gain()));
               csr_write(REG_KI, 32'd65535);
               csr_write(REG_KD, 32'(pick_gain()));
               csr_write(REG_ALPHA, 32'($urandom_range(0, 65535)));
               csr_write(REG_TPS, 32'd1);
               csr_write(REG_LIMIT, 32'd32767);
               goal = 270;
            end
            default: begin
               if ($urandom_range(0, 2) == 0)
                  csr_write(REG_TARGET, $urandom());
               else
                  csr_write(REG_TARGET, 32'($urandom_range(0, 4000)) - 32'd2000);
               csr_write(REG_KP, 32'(pick_gain()));
               csr_write(REG_KI, 32'(pick_gain()));
               csr_write(REG_KD, 32'(pick_gain()));
               csr_write(REG_ALPHA, ($urandom_range(0, 4) == 0) ? 32'd65535
                                                                : 32'($urandom_range(0, 65535)));
               case ($urandom_range(0, 9))
                  0, 1:    tps_pick = 16'd0;
                  2:       tps_pick = 16'($urandom_range(5, 12));
                  default: tps_pick = 16'($urandom_range(1, 4));
               endcase
               if (ph == 3) tps_pick = 16'd1;
               csr_write(REG_TPS, 32'(tps_pick));
               case ($urandom_range(0, 9))
                  0:       csr_write(REG_LIMIT, 32'd0);
                  1:       csr_write(REG_LIMIT, 32'd32767);
                  default: csr_write(REG_LIMIT, 32'($urandom_range(0, 32767)));
               endcase
               goal = 4;
            end
         endcase
         send_eager = (ph % 3 == 2);
         rsp_eager  = (ph % 4 == 1);
         // The receiver holds off while ticks keep coming, so the block backs up.
         if (ph == 3) hold_request = 1'b1;
         goal += updates_done;
         while (updates_done < goal)
            send_tick(pick_delta(ph == 2), pick_gap());
      end

      // Drain and let any stray beat show up.
      req_tvalid <= 1'b0;
      send_eager = 1'b0;
      while (due_outputs.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fault_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
